FILE: sv/bitmap_mark_find_next_clear_top_defines.svh
// Assertion macros for the bitmap mark / find-next-clear block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BITMAP_MARK_FIND_NEXT_CLEAR_TOP_DEFINES_SVH
`define BITMAP_MARK_FIND_NEXT_CLEAR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BMFNC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap block check failed");

// Next-cycle implication, checked out of reset
`define BMFNC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap block check failed");

`endif

FILE: sv/bmfnc_pkg.sv
// Shared types and constants for the bitmap mark / find-next-clear block.
// No dependencies.
`default_nettype none

package bmfnc_pkg;

    localparam int CAPACITY  = 4096;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = 13;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int NWORDS    = CAPACITY / WORD_BITS;
    localparam int ADDR_W    = $clog2(NWORDS);
    localparam int TDATA_W   = ((IDX_W + 7) / 8) * 8;

    localparam logic REQ_MARK = 1'b0;
    localparam logic REQ_FIND = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MARK,
        S_SCAN,
        S_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic rd_first;  // read the word holding the start index
        logic rd_next;   // advance to and read the following word
        logic wr_mark;   // write the read word back with the bit set
        logic set_err;   // result: out of range
        logic set_end;   // result: start equals the count
        logic set_scan;  // result: from the current scanned word
        logic load_out;  // move the result into the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_find;
        logic range_err;
        logic at_end;
        logic hit;
        logic last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: sv/bmfnc_dp.sv
// Datapath: count register, bitmap word memory with valid bits, scan logic
// and output register. Depends on bmfnc_pkg.
`default_nettype none

module bmfnc_dp
    import bmfnc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [IDX_W-1:0]   cfg_value,
    input  wire logic               in_req,
    input  wire logic [IDX_W-1:0]   in_index,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [IDX_W-1:0]        out_found,
    output logic                    out_status
);

    localparam logic [IDX_W-1:0] CAP_IDX  = IDX_W'(CAPACITY);
    localparam logic [IDX_W-1:0] WORD_IDX = IDX_W'(WORD_BITS);

    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [NWORDS-1:0]    valid_reg;

    logic [IDX_W-1:0]     cnt_reg;
    logic                 req_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]    ptr_reg;
    logic                 first_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     res_found_reg;
    logic                 res_status_reg;
    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_found_reg;
    logic                 out_status_reg;

    logic [IDX_W-1:0]     eff_cnt;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_en;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] start_mask;
    logic [WORD_BITS-1:0] zeros;
    logic [BIT_W-1:0]     zero_pos;
    logic [IDX_W-1:0]     pos;
    logic [IDX_W-1:0]     word_end;
    logic [IDX_W-1:0]     scan_found;

    // Lowest set bit of a word
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                p = BIT_W'(i);
            end
        end
        return p;
    endfunction

    // Clamp the count to capacity
    assign eff_cnt = (cnt_reg > CAP_IDX) ? CAP_IDX : cnt_reg;

    // Count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cfg_we)
        begin
            cnt_reg <= cfg_value;
        end
    end

    // Memory read port
    assign rd_en   = cmd.rd_first | cmd.rd_next;
    assign rd_addr = cmd.rd_first ? ptr_reg : ptr_reg + ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // A word never written reads as all clear
    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_mark)
        begin
            mem[ptr_reg] <= rd_data | (WORD_BITS'(1) << idx_reg[BIT_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr_mark)
        begin
            valid_reg[ptr_reg] <= 1'b1;
        end
    end

    // Scan: clear bits at or after the start in the current word
    assign start_mask = first_reg ? ({WORD_BITS{1'b1}} << idx_reg[BIT_W-1:0])
                                  : {WORD_BITS{1'b1}};
    assign zeros      = ~rd_data & start_mask;
    assign zero_pos   = lowest_set(zeros);
    assign pos        = IDX_W'({ptr_reg, zero_pos});
    assign word_end   = IDX_W'({ptr_reg, {BIT_W{1'b0}}}) + WORD_IDX;
    assign scan_found = ((|zeros) && (pos < eff_cnt)) ? pos : eff_cnt;

    // Request and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= in_req;
            idx_reg   <= in_index;
            ptr_reg   <= in_index[BIT_W +: ADDR_W];
            first_reg <= 1'b1;
        end
        else if (cmd.rd_next)
        begin
            ptr_reg   <= ptr_reg + ADDR_W'(1);
            first_reg <= 1'b0;
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            res_found_reg  <= '0;
            res_status_reg <= STATUS_OK;
        end
        else if (cmd.set_err)
        begin
            res_found_reg  <= '0;
            res_status_reg <= STATUS_ERR;
        end
        else if (cmd.set_end)
        begin
            res_found_reg  <= eff_cnt;
        end
        else if (cmd.set_scan)
        begin
            res_found_reg  <= scan_found;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_found  = out_found_reg;
    assign out_status = out_status_reg;

    // Status to the controller
    always_comb
    begin
        stat.req_find  = (req_reg == REQ_FIND);
        stat.range_err = (req_reg == REQ_FIND) ? (idx_reg > eff_cnt) : (idx_reg >= eff_cnt);
        stat.at_end    = (idx_reg == eff_cnt);
        stat.hit       = |zeros;
        stat.last      = (word_end >= eff_cnt);
        stat.out_free  = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

FILE: sv/bmfnc_ctrl.sv
// Controller state machine: sequences mark and find requests through the
// datapath. Depends on bmfnc_pkg.
`default_nettype none

module bmfnc_ctrl
    import bmfnc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.range_err || (stat.req_find && stat.at_end))
                begin
                    state_next = S_RESULT;
                end
                else if (stat.req_find)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                if (stat.hit || stat.last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DISPATCH:
            begin
                if (stat.range_err)
                begin
                    cmd.set_err = 1'b1;
                end
                else if (stat.req_find && stat.at_end)
                begin
                    cmd.set_end = 1'b1;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                end
            end
            S_MARK:
            begin
                cmd.wr_mark = 1'b1;
            end
            S_SCAN:
            begin
                if (stat.hit || stat.last)
                begin
                    cmd.set_scan = 1'b1;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            S_RESULT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/bitmap_mark_find_next_clear_top.sv
// Top level of the bitmap mark / find-next-clear block.
// Depends on bmfnc_pkg, bmfnc_ctrl, bmfnc_dp and the defines header.
//
// The block keeps a bitmap of 4096 entries in 128 words of 32 bits, all
// clear after reset (per-word valid bits, no clearing pass). A mark word
// (tuser 0) sets the bit of tdata's index if it is below the entry count;
// a find word (tuser 1) returns the first clear index at or after tdata's
// index, or the count when none is clear below it. Out-of-range requests
// return status 1 with index 0. One request is in flight at a time: a mark
// goes through dispatch, mark and result; a find through dispatch, a scan
// reading one word per cycle and result, or straight from dispatch to result
// when rejected or starting at the count. The result sits in an output
// register, so the next request is accepted while it waits to be taken.
// Write the entry count only while the block is idle.
`default_nettype none
`include "bitmap_mark_find_next_clear_top_defines.svh"

module bitmap_mark_find_next_clear_top
    import bmfnc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Configuration: entry_count
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [IDX_W-1:0]   cfg_data,
    // Request stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [12:0] index, rest zero
    input  wire logic               s_tuser,   // [0] req_type
    // Result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [12:0] found_index, rest zero
    output logic                    m_tuser    // [0] status
);

    cmd_t             cmd;
    stat_t            stat;
    logic [IDX_W-1:0] found;

    assign cfg_ready = 1'b1;

    bmfnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bmfnc_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_value  (cfg_data),
        .in_req     (s_tuser),
        .in_index   (s_tdata[IDX_W-1:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_found  (found),
        .out_status (m_tuser)
    );

    // Pad the result index to whole bytes
    assign m_tdata = TDATA_W'(found);

    // Checks
    `BMFNC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `BMFNC_ASSERT_SAME(a_err_zero_index, m_tvalid && (m_tuser == STATUS_ERR), found == '0)
    `BMFNC_ASSERT_SAME(a_found_in_bound, m_tvalid, found <= IDX_W'(CAPACITY))
    `BMFNC_ASSERT_SAME(a_single_cmd, 1'b1, $onehot0({cmd.set_err, cmd.set_end, cmd.set_scan}))

endmodule

`default_nettype wire
